[hw/rtl/wuia_pkg.sv]
// Package for the wrapping unique identifier allocator.
// Holds the field widths, default sizes and the request and status codes.
// No dependencies.
package wuia_pkg;

   localparam int ID_SPACE_DEF = 128;
   localparam int MAX_LIVE_DEF = 64;

   // fixed widths of the item fields
   localparam int ID_W     = 7;
   localparam int STATUS_W = 2;

   typedef enum logic {
      FUNC_ALLOC   = 1'b0,
      FUNC_RELEASE = 1'b1
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NOT_USED = 2'd2
   } status_type;

endpackage

[hw/rtl/wuia_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stands alone; no package needed.
module wuia_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/wrapping_unique_id_allocator_core.sv]
// Top level of the wrapping unique identifier allocator.
// Uses wuia_pkg and one wuia_ram instance for the used map.
//
// Hands out identifiers 1 .. ID_SPACE-1 in rising order from the one after the last
// given, wrapping back to 1; identifier 0 is never given. After reset the used map is
// cleared by a pass over every entry during which no item is taken. An allocate item
// scans up to ID_SPACE-1 map entries, or answers full without a scan when MAX_LIVE
// identifiers are already live; a release item reads its map entry, then checks it.
// The scan reads one map entry per cycle through the single RAM read port. One item
// is in work at a time; a finished result waits in an output register while the next
// item is accepted.
module wrapping_unique_id_allocator_core #(
   parameter int ID_SPACE = wuia_pkg::ID_SPACE_DEF,
   parameter int MAX_LIVE = wuia_pkg::MAX_LIVE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [6:0] release_id, [7] zero
   input  logic        req_tuser,   // [0] func
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [6:0] granted_id, [8:7] status, [15:9] zero
);

   import wuia_pkg::*;

   localparam int IW = $clog2(ID_SPACE);
   localparam int LW = $clog2(MAX_LIVE + 1);
   localparam logic [31:0] ID_SPACE_U = 32'(ID_SPACE);
   localparam logic [IW-1:0] ID_TOP   = IW'(ID_SPACE - 1);
   localparam logic [IW-1:0] TRY_LAST = IW'(ID_SPACE - 2);
   localparam logic [LW-1:0] LIVE_MAX = LW'(MAX_LIVE);

   typedef enum logic [4:0] {
      ST_CLEAR   = 5'b00001,
      ST_IDLE    = 5'b00010,
      ST_SCAN    = 5'b00100,
      ST_REL_CHK = 5'b01000,
      ST_DONE    = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [IW-1:0]    clr_ff, clr_in;
   logic [IW-1:0]    last_given_ff, last_given_in;
   logic [LW-1:0]    live_count_ff, live_count_in;
   logic [IW-1:0]    cand_ff, cand_in;
   logic [IW-1:0]    chk_cand_ff, chk_cand_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IW-1:0]    tries_ff, tries_in;
   logic [ID_W-1:0]  fin_id_ff, fin_id_in;
   status_type       fin_status_ff, fin_status_in;
   logic             out_vld_ff, out_vld_in;
   logic [ID_W-1:0]  out_id_ff, out_id_in;
   status_type       out_status_ff, out_status_in;

   logic             ram_wr_en;
   logic [IW-1:0]    ram_wr_addr;
   logic             ram_wr_data;
   logic [IW-1:0]    ram_rd_addr;
   logic             ram_rd_data;

   logic [ID_W-1:0]  rid;
   logic [IW-1:0]    rid_ext;
   logic             rid_ok;
   logic             req_acc;
   logic             out_load;

   function automatic logic [IW-1:0] next_cand(input logic [IW-1:0] c);
      logic [IW-1:0] n;
      if (c == ID_TOP) begin
         n = IW'(1);
      end else begin
         n = c + IW'(1);
      end
      return n;
   endfunction

   assign rid     = req_tdata[ID_W-1:0];
   assign rid_ext = IW'(rid);
   assign rid_ok  = (rid != '0) && ({{(32-ID_W){1'b0}}, rid} < ID_SPACE_U);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_load   = (state_ff == ST_DONE) && (!out_vld_ff || rsp_tready);

   wuia_ram #(
      .WIDTH (1),
      .DEPTH (ID_SPACE)
   ) u_used_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      last_given_in = last_given_ff;
      live_count_in = live_count_ff;
      cand_in       = cand_ff;
      chk_cand_in   = chk_cand_ff;
      chk_vld_in    = chk_vld_ff;
      tries_in      = tries_ff;
      fin_id_in     = fin_id_ff;
      fin_status_in = fin_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = chk_cand_ff;
      ram_wr_data   = 1'b0;
      ram_rd_addr   = rid_ext;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            clr_in      = clr_ff + IW'(1);
            if (clr_ff == ID_TOP) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               fin_id_in     = '0;
               fin_status_in = STATUS_OK;
               if (func_type'(req_tuser) == FUNC_ALLOC) begin
                  if (live_count_ff >= LIVE_MAX) begin
                     fin_status_in = STATUS_FULL;
                     state_in      = ST_DONE;
                  end else begin
                     cand_in    = next_cand(last_given_ff);
                     chk_vld_in = 1'b0;
                     tries_in   = '0;
                     state_in   = ST_SCAN;
                  end
               end else begin
                  if (rid_ok) begin
                     // map entry is read this cycle, checked in the next
                     chk_cand_in = rid_ext;
                     state_in    = ST_REL_CHK;
                  end else begin
                     fin_status_in = STATUS_NOT_USED;
                     state_in      = ST_DONE;
                  end
               end
            end
         end
         ST_SCAN: begin
            // read the next candidate while the previous one's entry is checked
            ram_rd_addr = cand_ff;
            cand_in     = next_cand(cand_ff);
            chk_cand_in = cand_ff;
            chk_vld_in  = 1'b1;
            if (chk_vld_ff) begin
               if (!ram_rd_data) begin
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = chk_cand_ff;
                  ram_wr_data   = 1'b1;
                  last_given_in = chk_cand_ff;
                  live_count_in = live_count_ff + LW'(1);
                  fin_id_in     = ID_W'(chk_cand_ff);
                  state_in      = ST_DONE;
               end else if (tries_ff == TRY_LAST) begin
                  fin_status_in = STATUS_FULL;
                  state_in      = ST_DONE;
               end else begin
                  tries_in = tries_ff + IW'(1);
               end
            end
         end
         ST_REL_CHK: begin
            if (ram_rd_data) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = chk_cand_ff;
               ram_wr_data = 1'b0;
               if (live_count_ff != '0) begin
                  live_count_in = live_count_ff - LW'(1);
               end
            end else begin
               fin_status_in = STATUS_NOT_USED;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_comb begin
      out_id_in     = out_id_ff;
      out_status_in = out_status_ff;
      out_vld_in    = out_vld_ff;
      if (out_load) begin
         out_id_in     = fin_id_ff;
         out_status_in = fin_status_ff;
         out_vld_in    = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         last_given_ff <= ID_TOP;
         live_count_ff <= '0;
         chk_vld_ff    <= 1'b0;
         tries_ff      <= '0;
         out_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         last_given_ff <= last_given_in;
         live_count_ff <= live_count_in;
         chk_vld_ff    <= chk_vld_in;
         tries_ff      <= tries_in;
         out_vld_ff    <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff       <= cand_in;
      chk_cand_ff   <= chk_cand_in;
      fin_id_ff     <= fin_id_in;
      fin_status_ff <= fin_status_in;
      out_id_ff     <= out_id_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(16-ID_W-STATUS_W){1'b0}}, out_status_ff, out_id_ff};

`ifndef SYNTH
   // live count never passes the limit
   a_live_limit: assert property (@(posedge clock) disable iff (reset)
      live_count_ff <= LIVE_MAX)
      else $error("live count above limit");

   // a grant raises the live count by exactly one
   a_grant_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && chk_vld_ff && !ram_rd_data)
      |=> live_count_ff == $past(live_count_ff) + LW'(1))
      else $error("grant did not bump live count");

   // a failing answer, full or not used, hands out no identifier
   a_full_no_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_status_ff != STATUS_OK) |-> out_id_ff == '0)
      else $error("identifier given with failing status");

   // the scan stops before it wraps onto its starting point
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> tries_ff <= TRY_LAST)
      else $error("scan ran past a full wrap");

   // no item taken until the clearing pass is over
   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && clr_ff != ID_TOP) |=> state_ff == ST_CLEAR)
      else $error("clearing pass cut short");
`endif

endmodule

[tb/wuia_checker.sv]
// Checker for the wrapping unique identifier allocator: watches both streams,
// predicts each answer from its own copy of the used map and compares.
// Depends on wuia_pkg for widths and codes.
module wuia_checker #(
   parameter int ID_SPACE = wuia_pkg::ID_SPACE_DEF,
   parameter int MAX_LIVE = wuia_pkg::MAX_LIVE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [6:0] release_id, [7] zero
   input  logic        req_tuser,   // [0] func
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [6:0] granted_id, [8:7] status, [15:9] zero
   output int          mismatch_count,
   output int          answers_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import wuia_pkg::*;

   typedef struct {
      logic [ID_W-1:0] granted;
      status_type      status;
   } answer_type;

   answer_type answers_due[$];
   logic       id_in_use [ID_SPACE];
   int         last_given;
   int         live_count;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Works out the answer to one request and updates the mirrored state.
   function automatic answer_type grant_or_release(input func_type f,
                                                   input logic [ID_W-1:0] rid);
      answer_type ans;
      int         cand;
      bit         found;
      ans.granted = '0;
      ans.status  = STATUS_OK;
      if (f == FUNC_ALLOC) begin
         if (live_count >= MAX_LIVE) begin
            ans.status = STATUS_FULL;
         end else begin
            cand  = last_given;
            found = 1'b0;
            // search upwards from the last one given, wrapping to 1
            for (int n = 0; n < ID_SPACE - 1 && !found; n++) begin
               cand = (cand + 1 >= ID_SPACE) ? 1 : cand + 1;
               if (!id_in_use[cand]) found = 1'b1;
            end
            if (found) begin
               id_in_use[cand] = 1'b1;
               last_given      = cand;
               live_count++;
               ans.granted     = cand[ID_W-1:0];
            end else begin
               ans.status = STATUS_FULL;
            end
         end
      end else begin
         if (rid != 0 && int'(rid) < ID_SPACE && id_in_use[rid]) begin
            id_in_use[rid] = 1'b0;
            if (live_count > 0) live_count--;
         end else begin
            ans.status = STATUS_NOT_USED;
         end
      end
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type      want;
      logic [ID_W-1:0] got_id;
      status_type      got_st;
      if (reset) begin
         foreach (id_in_use[i]) id_in_use[i] = 1'b0;
         last_given     = ID_SPACE - 1;
         live_count     = 0;
         mismatch_count = 0;
         answers_due.delete();
      end else begin
         // an answer always trails its request, so retire before pushing
         if (rsp_tvalid && rsp_tready) begin
            got_id = rsp_tdata[ID_W-1:0];
            got_st = status_type'(rsp_tdata[ID_W +: STATUS_W]);
            if (answers_due.size() == 0) begin
               report_mismatch($sformatf("result id %0d status %0d with no item outstanding",
                                         got_id, got_st));
            end else begin
               want = answers_due.pop_front();
               if (got_id !== want.granted)
                  report_mismatch($sformatf("granted_id got %0d, expected %0d",
                                            got_id, want.granted));
               if (got_st !== want.status)
                  report_mismatch($sformatf("status got %0d, expected %0d",
                                            got_st, want.status));
            end
         end
         if (req_tvalid && req_tready)
            answers_due.push_back(grant_or_release(func_type'(req_tuser),
                                                   req_tdata[ID_W-1:0]));
      end
      answers_pending <= answers_due.size();
   end

endmodule

[tb/tb_wrapping_unique_id_allocator_core.sv]
// Top of the identifier allocator testbench: clock, reset, request and
// response stimulus under several idle patterns, and the final verdict.
// Depends on wuia_pkg, wrapping_unique_id_allocator_core and wuia_checker.
module tb_wrapping_unique_id_allocator_core;
   timeunit 1ns;
   timeprecision 1ps;
   import wuia_pkg::*;

   localparam int RUN_LIMIT    = 3_000_000;
   localparam int PHASE_ITEMS  = 200;
   localparam int HOLD_CYCLES  = 400;
   localparam int ID_TOP       = ID_SPACE_DEF - 1;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   int mismatch_count;
   int answers_pending;
   int cycle_count  = 0;
   int sent_items   = 0;
   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;
   int hold_orders  = 0;
   int hold_seen    = 0;
   int hold_left    = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   wrapping_unique_id_allocator_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   wuia_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatch_count  (mismatch_count),
      .answers_pending (answers_pending)
   );

   // receiver: random stalls, or a long hold-off when one is ordered
   always @(posedge clock) begin
      if (hold_orders != hold_seen) begin
         hold_seen = hold_orders;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= RUN_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   // Leaves tvalid high on return; the next call either keeps it or drops it.
   task automatic send_item(input func_type f, input int id);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {1'b0, id[ID_W-1:0]};
      do @(posedge clock); while (!req_tready);
      sent_items++;
   endtask

   task automatic drain_answers();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (answers_pending != 0) @(posedge clock);
   endtask

   initial begin
      int phase_start;
      int kind;
      int len;
      int base;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reserved id, free ids, ignored id bits on allocate, search order
      send_item(FUNC_RELEASE, 0);
      send_item(FUNC_RELEASE, ID_TOP);
      send_item(FUNC_ALLOC, ID_TOP);
      send_item(FUNC_ALLOC, 0);
      send_item(FUNC_ALLOC, 'h55);
      send_item(FUNC_RELEASE, 2);
      send_item(FUNC_RELEASE, 2);
      send_item(FUNC_ALLOC, 'h2a);
      send_item(FUNC_RELEASE, 1);
      send_item(FUNC_RELEASE, 3);
      send_item(FUNC_RELEASE, 4);
      send_item(FUNC_ALLOC, 0);
      send_item(FUNC_RELEASE, 5);
      send_item(FUNC_RELEASE, 'h2a);
      send_item(FUNC_RELEASE, 'h55);
      drain_answers();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
            1: begin tx_idle_pct = 77; rx_stall_pct <= 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct <= 77; end
            default: begin tx_idle_pct = 6; rx_stall_pct <= 6; end
         endcase
         phase_start = sent_items;
         // allocate runs fill up to the limit and push past the wrap; release
         // sweeps over a window hit the ids that sequential grants left in use
         while (sent_items - phase_start < PHASE_ITEMS) begin
            kind = $urandom_range(3);
            len  = (kind == 0) ? $urandom_range(1, 72) : $urandom_range(1, 40);
            base = $urandom_range(1, ID_TOP);
            for (int k = 0; k < len; k++) begin
               case (kind)
                  0: send_item(FUNC_ALLOC, $urandom_range(ID_TOP));
                  1: send_item(FUNC_RELEASE, $urandom_range(ID_TOP));
                  2: send_item(func_type'($urandom_range(1)), $urandom_range(ID_TOP));
                  default: send_item(FUNC_RELEASE, ((base + k - 1) % ID_TOP) + 1);
               endcase
            end
         end
         if (p == 0) begin
            // receiver holds off while items keep coming, so the input backs up
            hold_orders <= hold_orders + 1;
            for (int k = 0; k < 24; k++)
               send_item(func_type'($urandom_range(1)), $urandom_range(ID_TOP));
         end
         drain_answers();
      end

      repeat (2 * ID_SPACE_DEF) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[wrapping_unique_id_allocator_core.f]
hw/rtl/wuia_pkg.sv
hw/rtl/wuia_ram.sv
hw/rtl/wrapping_unique_id_allocator_core.sv
tb/wuia_checker.sv
tb/tb_wrapping_unique_id_allocator_core.sv
